// ===== design/most_frequent_kmer_counter_core_defines.svh =====
// Assertion macros used by the k-mer counter RTL.
`ifndef MOST_FREQUENT_KMER_COUNTER_CORE_DEFINES_SVH
`define MOST_FREQUENT_KMER_COUNTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MFKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mfkc assertion failed");
// Next-cycle implication.
`define MFKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mfkc assertion failed");
`else
`define MFKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MFKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/mfkc_pkg.sv =====
// Types, constants and helper functions of the k-mer counter.
package mfkc_pkg;

	localparam int MAX_K       = 8;
	localparam int KMER_W      = 2 * MAX_K;
	localparam int COUNT_W     = 16;
	localparam int TIE_DEPTH   = 64;
	localparam int TIE_AW      = $clog2(TIE_DEPTH);
	localparam int TIE_CW      = $clog2(TIE_DEPTH + 1);
	localparam int FILL_W      = $clog2(MAX_K + 1);
	localparam int KLEN_W      = 4;
	localparam int SYM_W       = 8;
	localparam int CMD_W       = 2;
	localparam int IN_W        = 16;
	localparam int OUT_W       = 72;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [KLEN_W-1:0]  KLEN_RESET = KLEN_W'(4);
	localparam logic [PADDR_W-1:0] ADDR_KMER_LENGTH = '0;

	// commands carried in tuser
	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	localparam logic [SYM_W-1:0] SYM_A = 8'h41;
	localparam logic [SYM_W-1:0] SYM_T = 8'h54;
	localparam logic [SYM_W-1:0] SYM_C = 8'h43;
	localparam logic [SYM_W-1:0] SYM_G = 8'h47;

	typedef struct packed {
		logic       valid;
		logic [1:0] code;
	} sym_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic clr_start;
		logic clr_run;
		logic shift;
		logic update;
		logic tie_rd;
		logic tie_cap;
		logic load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic kmer_hit;
		logic clr_last;
	} dp_stat_t;

	function automatic sym_t sym_code(input logic [SYM_W-1:0] b);
		sym_t s;
		s.valid = 1'b1;
		unique case (b)
			SYM_A:   s.code = 2'd0;
			SYM_T:   s.code = 2'd1;
			SYM_C:   s.code = 2'd2;
			SYM_G:   s.code = 2'd3;
			default: begin
				s.valid = 1'b0;
				s.code  = 2'd0;
			end
		endcase
		return s;
	endfunction

	// clamp k into 1..MAX_K
	function automatic logic [KLEN_W-1:0] k_eff(input logic [KLEN_W-1:0] kl);
		logic [KLEN_W-1:0] k;
		if (kl == '0) begin
			k = KLEN_W'(1);
		end else if (kl > KLEN_W'(MAX_K)) begin
			k = KLEN_W'(MAX_K);
		end else begin
			k = kl;
		end
		return k;
	endfunction

	// low 2k bits set
	function automatic logic [KMER_W-1:0] kmer_mask(input logic [KLEN_W-1:0] k);
		logic [KMER_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_K; i++) begin
			if (KLEN_W'(i) < k) m[2*i +: 2] = 2'b11;
		end
		return m;
	endfunction

endpackage

// ===== design/mfkc_ctrl.sv =====
// Sequencing state machine of the k-mer counter.
module mfkc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mfkc_pkg::CMD_W-1:0]  s_cmd,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  mfkc_pkg::dp_stat_t          stat,
	output mfkc_pkg::dp_cmd_t           cmd
);
	import mfkc_pkg::*;

	localparam logic [2:0] ST_BOOT_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_SHIFT    = 3'd2;
	localparam logic [2:0] ST_UPD      = 3'd3;
	localparam logic [2:0] ST_TRD      = 3'd4;
	localparam logic [2:0] ST_TDAT     = 3'd5;
	localparam logic [2:0] ST_CLR      = 3'd6;
	localparam logic [2:0] ST_RESULT   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_BOOT_CLR: begin
				cmd.clr_run = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					unique case (s_cmd)
						CMD_PUSH:  state_d = ST_SHIFT;
						CMD_READ:  state_d = ST_TRD;
						CMD_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = ST_CLR;
						end
						CMD_NOP:   state_d = ST_RESULT;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = stat.kmer_hit ? ST_UPD : ST_RESULT;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_TRD: begin
				cmd.tie_rd = 1'b1;
				state_d    = ST_TDAT;
			end
			ST_TDAT: begin
				cmd.tie_cap = 1'b1;
				state_d     = ST_RESULT;
			end
			ST_CLR: begin
				cmd.clr_run = 1'b1;
				if (stat.clr_last) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BOOT_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/mfkc_datapath.sv =====
// Window, counter table, best count, tie list and result register.
module mfkc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mfkc_pkg::dp_cmd_t             cmd,
	output mfkc_pkg::dp_stat_t            stat,
	input  logic [mfkc_pkg::KLEN_W-1:0]   kmer_length,
	input  logic [mfkc_pkg::SYM_W-1:0]    symbol_byte,
	input  logic [mfkc_pkg::TIE_AW-1:0]   tie_slot,
	output logic                          out_full,
	output logic [mfkc_pkg::OUT_W-1:0]    out_data
);
	import mfkc_pkg::*;

	localparam int TABLE_DEPTH = 1 << KMER_W;

	logic [COUNT_W-1:0] cnt_mem [TABLE_DEPTH];
	logic [KMER_W-1:0]  tie_mem [TIE_DEPTH];

	logic [SYM_W-1:0]   sym_q;
	logic [TIE_AW-1:0]  slot_q;
	logic [KMER_W-1:0]  window_q;
	logic [FILL_W-1:0]  fill_q;
	logic [COUNT_W-1:0] best_q;
	logic [TIE_CW-1:0]  ties_q;
	logic               lost_q;
	logic [KMER_W-1:0]  clr_addr_q;

	logic               res_full_q;
	logic [KMER_W-1:0]  res_code_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [KMER_W-1:0]  res_entry_q;
	logic [COUNT_W-1:0] cnt_rd_q;
	logic [KMER_W-1:0]  tie_rd_q;
	logic               out_full_q;
	logic [OUT_W-1:0]   out_data_q;

	sym_t               sc;
	logic [KLEN_W-1:0]  k;
	logic [KMER_W-1:0]  win_nx;
	logic [FILL_W-1:0]  fill_nx;
	logic [KMER_W-1:0]  code_nx;
	logic               hit;
	logic               sat;
	logic [COUNT_W-1:0] cnt_inc;
	logic               cnt_we;
	logic [KMER_W-1:0]  cnt_waddr;
	logic [COUNT_W-1:0] cnt_wdata;
	logic               new_best;
	logic               tie_app;
	logic               tie_we;
	logic [TIE_AW-1:0]  tie_waddr;
	logic               has_room;

	// symbol shift
	always_comb begin
		sc      = sym_code(sym_q);
		k       = k_eff(kmer_length);
		win_nx  = {window_q[KMER_W-3:0], sc.code};
		fill_nx = (fill_q < FILL_W'(MAX_K)) ? fill_q + FILL_W'(1) : fill_q;
		hit     = sc.valid && (fill_nx >= FILL_W'(k));
		code_nx = win_nx & kmer_mask(k);
	end

	// counter update
	always_comb begin
		sat       = (cnt_rd_q == COUNT_MAX);
		cnt_inc   = cnt_rd_q + COUNT_W'(1);
		new_best  = cmd.update && !sat && (cnt_inc > best_q);
		has_room  = (ties_q < TIE_CW'(TIE_DEPTH));
		tie_app   = cmd.update && !sat && (cnt_inc == best_q);
		tie_we    = new_best || (tie_app && has_room);
		tie_waddr = new_best ? '0 : ties_q[TIE_AW-1:0];
		cnt_we    = cmd.clr_run || (cmd.update && !sat);
		cnt_waddr = cmd.clr_run ? clr_addr_q : res_code_q;
		cnt_wdata = cmd.clr_run ? '0 : cnt_inc;
	end

	assign stat.kmer_hit = hit;
	assign stat.clr_last = (clr_addr_q == '1);

	// counter table, single write port and registered read
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		if (cmd.shift) cnt_rd_q <= cnt_mem[code_nx];
	end

	// tie list
	always_ff @(posedge clk) begin
		if (tie_we) tie_mem[tie_waddr] <= res_code_q;
		if (cmd.tie_rd) tie_rd_q <= tie_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			fill_q     <= '0;
			best_q     <= '0;
			ties_q     <= '0;
			lost_q     <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr_start) begin
				window_q   <= '0;
				fill_q     <= '0;
				best_q     <= '0;
				ties_q     <= '0;
				lost_q     <= 1'b0;
				clr_addr_q <= '0;
			end else begin
				if (cmd.clr_run) clr_addr_q <= clr_addr_q + KMER_W'(1);
				if (cmd.shift && sc.valid) begin
					window_q <= win_nx;
					fill_q   <= fill_nx;
				end
				if (new_best) begin
					best_q <= cnt_inc;
					ties_q <= TIE_CW'(1);
					lost_q <= 1'b0;
				end else if (tie_app) begin
					if (has_room) begin
						ties_q <= ties_q + TIE_CW'(1);
					end else begin
						lost_q <= 1'b1;
					end
				end
			end
		end
	end

	// item and result fields
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sym_q       <= symbol_byte;
			slot_q      <= tie_slot;
			res_full_q  <= 1'b0;
			res_code_q  <= '0;
			res_count_q <= '0;
			res_entry_q <= '0;
		end
		if (cmd.shift && hit) res_code_q <= code_nx;
		if (cmd.update) begin
			res_full_q  <= 1'b1;
			res_count_q <= sat ? cnt_rd_q : cnt_inc;
		end
		if (cmd.tie_cap) begin
			res_entry_q <= ({1'b0, slot_q} < ties_q) ? tie_rd_q : '0;
		end
		if (cmd.load) begin
			out_full_q <= res_full_q;
			out_data_q <= {lost_q, res_entry_q, ties_q, best_q, res_count_q, res_code_q};
		end
	end

	assign out_full = out_full_q;
	assign out_data = out_data_q;

endmodule

// ===== design/most_frequent_kmer_counter_core.sv =====
// Top level of the streaming most-frequent k-mer counter.
//
// Counts k-mers over a stream of DNA text. Each request carries a command in
// s_tuser: push a byte (A/T/C/G map to codes 0..3, anything else is dropped),
// read one slot of the tie list, clear, or a no-op that only reports status.
// Every request returns exactly one response with the k-mer just counted (if
// any), its saturating count, the best count, the tie list length, the
// requested tie entry and the overflow flag. k is set through the APB
// register at address 0 (reset 4; 0 acts as 1, above 8 acts as 8).
// One request is handled at a time. A push that completes a k-mer passes from
// acceptance to the response register through accept, shift with counter
// read, counter write and load; a push that counts nothing skips the counter
// write, a tie read passes through tie read and tie capture, and a no-op goes
// straight to load. The 64K x 16 counter table has a single write port and is
// swept to zero one word a cycle on a clear request and after reset, and
// s_tready stays low while that sweep runs (the register port works
// throughout). The response register lets the next request be accepted
// while a response still waits on m_tready.
`include "most_frequent_kmer_counter_core_defines.svh"

module most_frequent_kmer_counter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] symbol_byte, [13:8] tie_slot, [15:14] zero
	input  logic [mfkc_pkg::IN_W-1:0]      s_tdata,
	// [1:0] cmd
	input  logic [mfkc_pkg::CMD_W-1:0]     s_tuser,
	// response stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [15:0] kmer_code, [31:16] kmer_count, [47:32] best_count,
	// [54:48] tie_count, [70:55] tie_entry, [71] tie_overflow
	output logic [mfkc_pkg::OUT_W-1:0]     m_tdata,
	// [0] window_full
	output logic                           m_tuser,
	// register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mfkc_pkg::PADDR_W-1:0]   paddr,
	input  logic [mfkc_pkg::PDATA_W-1:0]   pwdata,
	output logic [mfkc_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import mfkc_pkg::*;

	logic [KLEN_W-1:0] kmer_length_q;
	dp_cmd_t           dp_cmd;
	dp_stat_t          dp_stat;

	// register file: kmer_length only
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_KMER_LENGTH) ?
		{{(PDATA_W-KLEN_W){1'b0}}, kmer_length_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KLEN_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_KMER_LENGTH)) begin
			kmer_length_q <= pwdata[KLEN_W-1:0];
		end
	end

	mfkc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_cmd    (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	mfkc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.kmer_length (kmer_length_q),
		.symbol_byte (s_tdata[SYM_W-1:0]),
		.tie_slot    (s_tdata[SYM_W +: TIE_AW]),
		.out_full    (m_tuser),
		.out_data    (m_tdata)
	);

	// one request in flight: no acceptance right after an acceptance
	`MFKC_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// no counted k-mer means zero code and count
	`MFKC_ASSERT_IMP(a_empty_kmer, clk, arst_n, m_tvalid && !m_tuser, m_tdata[31:0] == '0)
	// a counted k-mer never beats the best count and is never zero
	`MFKC_ASSERT_IMP(a_count_vs_best, clk, arst_n, m_tvalid && m_tuser, (m_tdata[31:16] != '0) && (m_tdata[31:16] <= m_tdata[47:32]))
	// overflow only with a full tie list
	`MFKC_ASSERT_IMP(a_overflow_full, clk, arst_n, m_tvalid && m_tdata[71], m_tdata[54:48] == TIE_CW'(TIE_DEPTH))

endmodule

// ===== tb/tb_most_frequent_kmer_counter_core.sv =====
// Self-checking stream/register testbench for most_frequent_kmer_counter_core.
module tb_most_frequent_kmer_counter_core;
	import mfkc_pkg::*;

	// nucleotide codes as the counter stores them
	typedef enum logic [1:0] {NT_A, NT_T, NT_C, NT_G} nt_e;

	// one request as it travels on s_tuser / s_tdata
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [SYM_W-1:0] sym;
		logic [TIE_AW-1:0] slot;
	} kmer_req_t;

	// one response, split into its fields
	typedef struct packed {
		logic               full;
		logic [KMER_W-1:0]  code;
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] best;
		logic [TIE_CW-1:0]  ties;
		logic [KMER_W-1:0]  entry;
		logic               lost;
	} kmer_resp_t;

	// ---------------------------------------------------------------- DUT I/O
	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic [CMD_W-1:0]    s_tuser  = CMD_NOP;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [PDATA_W-1:0]  pwdata   = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	most_frequent_kmer_counter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------- predictor state
	logic [COUNT_W-1:0] tally [0:(1<<KMER_W)-1];  // per-k-mer counters
	logic [KMER_W-1:0]  tie_codes [0:TIE_DEPTH-1];
	logic [KMER_W-1:0]  win_codes;
	logic [FILL_W-1:0]  win_fill;
	logic [COUNT_W-1:0] best_cnt;
	logic [TIE_CW-1:0]  ties_held;
	logic               ties_lost;
	logic [KLEN_W-1:0]  cfg_klen = KLEN_RESET;   // mirrors the k register

	kmer_req_t  request_queue[$];     // requests not yet offered
	kmer_resp_t predicted_reports[$]; // responses owed by the DUT
	kmer_req_t  cur_req;              // request currently on the bus
	int         n_queued   = 0;
	int         n_accepted = 0;
	int         mismatches = 0;

	// wipe counters, window, best and tie list; k register survives
	function automatic void clear_counts();
		for (int i = 0; i < (1 << KMER_W); i++) tally[i] = '0;
		win_codes = '0;
		win_fill  = '0;
		best_cnt  = '0;
		ties_held = '0;
		ties_lost = 1'b0;
	endfunction

	// Advance the predicted counter state by one request and return the
	// response the DUT owes for it.
	function automatic kmer_resp_t count_kmer(input kmer_req_t r);
		kmer_resp_t         o;
		nt_e                nt;
		logic               is_base;
		logic [KLEN_W-1:0]  k;
		logic [KMER_W-1:0]  code;
		logic [COUNT_W-1:0] c;
		o = '0;
		case (r.cmd)
			CMD_PUSH: begin
				is_base = 1'b1;
				nt = NT_A;
				case (r.sym)
					SYM_A:   nt = NT_A;
					SYM_T:   nt = NT_T;
					SYM_C:   nt = NT_C;
					SYM_G:   nt = NT_G;
					default: is_base = 1'b0;
				endcase
				if (is_base) begin
					// 0 behaves as 1, anything above MAX_K as MAX_K
					if (cfg_klen == 0)          k = KLEN_W'(1);
					else if (cfg_klen > MAX_K)  k = KLEN_W'(MAX_K);
					else                        k = cfg_klen;
					win_codes = {win_codes[KMER_W-3:0], nt};
					if (win_fill < MAX_K) win_fill++;
					if (win_fill >= k) begin
						code = win_codes & KMER_W'((32'd1 << (2 * k)) - 1);
						c = tally[code];
						// saturated counter: nothing moves
						if (c != COUNT_MAX) begin
							c++;
							tally[code] = c;
							if (c > best_cnt) begin
								best_cnt     = c;
								tie_codes[0] = code;
								ties_held    = TIE_CW'(1);
								ties_lost    = 1'b0;
							end else if (c == best_cnt) begin
								if (ties_held < TIE_DEPTH) begin
									tie_codes[ties_held[TIE_AW-1:0]] = code;
									ties_held++;
								end else begin
									ties_lost = 1'b1;
								end
							end
						end
						o.full  = 1'b1;
						o.code  = code;
						o.count = c;
					end
				end
			end
			CMD_READ: begin
				// slots past the list end read as zero
				if (r.slot < ties_held) o.entry = tie_codes[r.slot];
			end
			CMD_CLEAR: clear_counts();
			default: ;
		endcase
		o.best = best_cnt;
		o.ties = ties_held;
		o.lost = ties_lost;
		return o;
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// ----------------------------------------------------------------- driver
	// Bursts of back-to-back requests separated by random gaps. The predictor
	// runs at the accepting edge, so config never changes under it.
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predicted_reports.push_back(count_kmer(cur_req));
			n_accepted++;
		end
		if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				cur_req  = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {2'b00, cur_req.slot, cur_req.sym};
				s_tuser  <= cur_req.cmd;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					// one burst in four runs straight into the next
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// m_tready follows a 16-bit pattern, redrawn each period: always ready,
	// random, mostly ready or mostly stalled.
	logic [15:0] stall_bits = '1;
	logic [3:0]  stall_pos  = '0;
	kmer_resp_t  want;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (predicted_reports.size() == 0) begin
				note_mismatch("response with nothing outstanding", m_tdata[15:0], 0);
			end else begin
				want = predicted_reports.pop_front();
				if (m_tuser !== want.full)
					note_mismatch("window_full", m_tuser, want.full);
				if (m_tdata[15:0] !== want.code)
					note_mismatch("kmer_code", m_tdata[15:0], want.code);
				if (m_tdata[31:16] !== want.count)
					note_mismatch("kmer_count", m_tdata[31:16], want.count);
				if (m_tdata[47:32] !== want.best)
					note_mismatch("best_count", m_tdata[47:32], want.best);
				if (m_tdata[54:48] !== want.ties)
					note_mismatch("tie_count", m_tdata[54:48], want.ties);
				if (m_tdata[70:55] !== want.entry)
					note_mismatch("tie_entry", m_tdata[70:55], want.entry);
				if (m_tdata[71] !== want.lost)
					note_mismatch("tie_overflow", m_tdata[71], want.lost);
			end
		end
		if (stall_pos == 0) begin
			case ($urandom_range(0, 3))
				0:       stall_bits = '1;
				1:       stall_bits = 16'($urandom);
				2:       stall_bits = 16'($urandom | $urandom);
				default: stall_bits = 16'($urandom & $urandom);
			endcase
		end
		m_tready  <= stall_bits[stall_pos];
		stall_pos <= stall_pos + 1'b1;
	end

	// -------------------------------------------------------------- stimulus
	task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
			input logic [TIE_AW-1:0] slot);
		kmer_req_t r;
		r.cmd  = cmd;
		r.sym  = sym;
		r.slot = slot;
		request_queue.push_back(r);
		n_queued++;
	endtask

	function automatic logic [SYM_W-1:0] random_base();
		nt_e n;
		n = nt_e'($urandom_range(0, 3));
		case (n)
			NT_A:    return SYM_A;
			NT_T:    return SYM_T;
			NT_C:    return SYM_C;
			default: return SYM_G;
		endcase
	endfunction

	// mostly clean DNA, with some junk bytes, tie reads and no-ops mixed in
	task automatic queue_random(input int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 78)
				queue_req(CMD_PUSH, random_base(), TIE_AW'($urandom));
			else if (sel < 86)
				queue_req(CMD_PUSH, SYM_W'($urandom_range(0, 255)), TIE_AW'($urandom));
			else if (sel < 91)
				queue_req(CMD_READ, SYM_W'($urandom), TIE_AW'($urandom_range(0, 7)));
			else if (sel < 96)
				queue_req(CMD_READ, SYM_W'($urandom), TIE_AW'($urandom_range(0, 63)));
			else
				queue_req(CMD_NOP, SYM_W'($urandom), TIE_AW'($urandom));
		end
	endtask

	// hold off until every request is in and every response is out
	task automatic wait_drained();
		while (n_accepted != n_queued || predicted_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// two-phase register write; lands at the access edge with pready high
	task automatic write_klen(input logic [KLEN_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_KMER_LENGTH;
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_klen = v;
	endtask

	task automatic run_phase(input logic [KLEN_W-1:0] k, input bit wipe, input int n);
		wait_drained();
		write_klen(k);
		if (wipe) queue_req(CMD_CLEAR, '0, '0);
		queue_random(n);
	endtask

	initial begin
		clear_counts();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset length of 4: first full window, the
		// all-G code, junk bytes, reads inside and past the list, no-op,
		// a tie at the best count, and a clear.
		queue_req(CMD_PUSH, SYM_A, '0);
		queue_req(CMD_PUSH, SYM_T, '0);
		queue_req(CMD_PUSH, SYM_C, '0);
		queue_req(CMD_PUSH, SYM_G, '0);
		repeat (4) queue_req(CMD_PUSH, SYM_G, '1);
		queue_req(CMD_PUSH, 8'h00, '0);
		queue_req(CMD_PUSH, 8'hFF, '1);
		queue_req(CMD_PUSH, "a", '0);
		queue_req(CMD_PUSH, "N", '0);
		queue_req(CMD_READ, '0, 6'd0);
		queue_req(CMD_READ, '1, 6'd63);
		queue_req(CMD_NOP, '1, '1);
		queue_req(CMD_READ, '0, 6'd1);
		repeat (5) queue_req(CMD_PUSH, SYM_A, '0);
		queue_req(CMD_READ, '0, 6'd0);
		queue_req(CMD_CLEAR, '1, '1);
		queue_req(CMD_PUSH, SYM_A, '0);
		queue_req(CMD_READ, '0, 6'd0);
		queue_req(CMD_NOP, '0, '0);
		queue_random(150);

		// Length sweep, including both ends of the 4-bit register. Table
		// and window carry across most length changes on purpose. The
		// k=8 phase starts clean so distinct k-mers pile up past the
		// tie list depth.
		run_phase(4'd1,  1'b0, 200);
		run_phase(4'd0,  1'b0, 150);
		run_phase(4'd8,  1'b1, 250);
		run_phase(4'd15, 1'b0, 150);
		run_phase(4'd2,  1'b1, 200);
		run_phase(4'd3,  1'b0, 150);
		run_phase(4'd5,  1'b0, 150);
		run_phase(4'd6,  1'b0, 100);
		run_phase(4'd7,  1'b0, 100);
		run_phase(4'd12, 1'b0, 100);

		wait_drained();
		queue_random(60);

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && predicted_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog: the reset sweep and a handful of 64K clears finish well
	// before it fires
	initial begin
		#8000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
